// ===== rtl/bpc_pkg.sv =====
// Package for the barometric pressure and temperature compensation block.
// Holds payload types, datapath widths, register indexes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package bpc_pkg;

	// field widths
	localparam int RAW_W  = 24;
	localparam int CAL_W  = 16;
	localparam int OUT_W  = 32;
	localparam int IDX_W  = 3;

	// datapath widths
	localparam int DT_W   = 25;               // D2 - C5*256, signed
	localparam int MUL_A_W = 35;              // signed multiplicand
	localparam int MUL_B_W = 24;              // unsigned multiplier, one bit per cycle
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int OFF_W  = 36;
	localparam int SENS_W = 35;
	localparam int PDIF_W = 39;

	localparam logic [OUT_W-1:0] TEMP_BASE = 32'd2000;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} bpc_reg_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
		logic             relatch_ground;
	} bpc_sample_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] temperature;
		logic signed [OUT_W-1:0] pressure;
		logic signed [OUT_W-1:0] ground_pressure;
	} bpc_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEMP,
		ST_OFF,
		ST_SENS,
		ST_PRES,
		ST_DONE
	} bpc_state_t;

endpackage

// ===== rtl/bpc_if.sv =====
// Handshake channels of the compensation block: sample in, result out, register writes.
// Depends on bpc_pkg for the payload types.
`timescale 1ns / 1ps

interface bpc_sample_if;
	logic                 valid;
	logic                 ready;
	bpc_pkg::bpc_sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpc_result_if;
	logic                 valid;
	logic                 ready;
	bpc_pkg::bpc_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bpc_pkg::IDX_W-1:0]      index;
	logic [bpc_pkg::CAL_W-1:0]      wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/bpc_mul.sv =====
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle. Depends on bpc_pkg for widths.
`timescale 1ns / 1ps

module bpc_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bpc_pkg::MUL_A_W-1:0] a,
	input  logic [bpc_pkg::MUL_B_W-1:0] b,
	output logic                        done,
	output logic [bpc_pkg::PROD_W-1:0]  product
);
	import bpc_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_B_W - 1);

	logic [MUL_A_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [PROD_W-1:0]  acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_A_W:0]   sum;
	logic [PROD_W-1:0]  acc_next;

	// add the multiplicand into the upper half, then shift right arithmetically
	always_comb begin
		sum = {acc_q[PROD_W-1], acc_q[PROD_W-1:MUL_B_W]}
			+ (b_q[0] ? {a_q[MUL_A_W-1], a_q} : '0);
		acc_next = {sum, acc_q[MUL_B_W-1:1]};
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and partial product
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
			b_q   <= b_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
// Top level of the first-order barometric pressure and temperature compensation.
// Depends on bpc_pkg, the channel interfaces in bpc_if and the serial multiplier bpc_mul.
`timescale 1ns / 1ps

// One sample word (raw pressure, raw temperature, relatch flag) gives one result word
// (temperature in 0.01 degC, pressure in 0.01 mbar, ground reference pressure). The four
// products of the compensation run one after another through a single bit-serial
// multiplier, each as one operand load and 24 shift-add steps. The result register loads
// after the fourth product, and the sequencer can take the next sample in the cycle after
// that, so only one sample is in progress at a time. The next sample is taken even while
// the previous result waits to be read. Once that sample is done too, the input stalls
// until the result register is free. The first sample after reset, and any sample with
// relatch_ground set, latches its pressure as the ground reference. Calibration writes
// (C1..C6 at indexes 0..5, others ignored) are always ready and must only be issued
// while no sample is in progress.
module baro_pressure_temp_compensation (
	input  logic        clk,
	input  logic        arst_n,
	bpc_sample_if.sink  sample,
	bpc_result_if.source result,
	bpc_cfg_if.sink     cfg
);
	import bpc_pkg::*;

	// calibration words
	logic [CAL_W-1:0] cal_pressure_sens_q;
	logic [CAL_W-1:0] cal_pressure_offset_q;
	logic [CAL_W-1:0] cal_tc_sens_q;
	logic [CAL_W-1:0] cal_tc_offset_q;
	logic [CAL_W-1:0] cal_ref_temp_q;
	logic [CAL_W-1:0] cal_tc_temp_q;

	bpc_state_t state_q, state_next;

	logic [RAW_W-1:0]  d1_q;
	logic              relatch_q;
	logic [DT_W-1:0]   dt_q;
	logic [OUT_W-1:0]  temp_q;
	logic [OFF_W-1:0]  off_q;
	logic [OUT_W-1:0]  p_q;
	logic [OUT_W-1:0]  ground_ref_q;
	logic              ground_valid_q;
	logic              res_valid_q;
	bpc_result_t       res_q;

	logic              accept;
	logic              res_load;
	logic [DT_W-1:0]   dt_in;
	logic [SENS_W-1:0] sens_next;
	logic [PDIF_W-1:0] p_diff;
	logic [OUT_W-1:0]  ground_next;

	logic               mul_start;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic               mul_done;
	logic [PROD_W-1:0]  mul_prod;

	bpc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	// write calibration words
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_pressure_sens_q   <= '0;
			cal_pressure_offset_q <= '0;
			cal_tc_sens_q         <= '0;
			cal_tc_offset_q       <= '0;
			cal_ref_temp_q        <= '0;
			cal_tc_temp_q         <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_C1:  cal_pressure_sens_q   <= cfg.wdata;
				REG_C2:  cal_pressure_offset_q <= cfg.wdata;
				REG_C3:  cal_tc_sens_q         <= cfg.wdata;
				REG_C4:  cal_tc_offset_q       <= cfg.wdata;
				REG_C5:  cal_ref_temp_q        <= cfg.wdata;
				REG_C6:  cal_tc_temp_q         <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// dT from the incoming sample, and the derived terms from the multiplier result
	always_comb begin
		dt_in = {1'b0, sample.data.raw_temperature} - {1'b0, cal_ref_temp_q, 8'b0};
		sens_next = {4'b0, cal_pressure_sens_q, 15'b0} + mul_prod[42:8];
		p_diff = {mul_prod[PROD_W-1], mul_prod[PROD_W-1:21]} - {{3{off_q[OFF_W-1]}}, off_q};
		ground_next = (!ground_valid_q || relatch_q) ? p_q : ground_ref_q;
	end

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign res_load     = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and multiplier operands
	always_comb begin
		state_next = state_q;
		mul_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (sample.valid) begin
					mul_start  = 1'b1;
					mul_a      = {{(MUL_A_W-DT_W){dt_in[DT_W-1]}}, dt_in};
					mul_b      = {8'b0, cal_tc_temp_q};
					state_next = ST_TEMP;
				end
			end
			ST_TEMP: begin
				if (mul_done) begin
					mul_start  = 1'b1;
					mul_a      = {{(MUL_A_W-DT_W){dt_q[DT_W-1]}}, dt_q};
					mul_b      = {8'b0, cal_tc_offset_q};
					state_next = ST_OFF;
				end
			end
			ST_OFF: begin
				if (mul_done) begin
					mul_start  = 1'b1;
					mul_a      = {{(MUL_A_W-DT_W){dt_q[DT_W-1]}}, dt_q};
					mul_b      = {8'b0, cal_tc_sens_q};
					state_next = ST_SENS;
				end
			end
			ST_SENS: begin
				if (mul_done) begin
					mul_start  = 1'b1;
					mul_a      = sens_next;
					mul_b      = d1_q;
					state_next = ST_PRES;
				end
			end
			ST_PRES: begin
				if (mul_done) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_valid_q || result.ready) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// hold the sample and the intermediate terms
	always_ff @(posedge clk) begin
		if (accept) begin
			d1_q      <= sample.data.raw_pressure;
			relatch_q <= sample.data.relatch_ground;
			dt_q      <= dt_in;
		end
		if (state_q == ST_TEMP && mul_done) begin
			temp_q <= mul_prod[54:23] + TEMP_BASE;
		end
		if (state_q == ST_OFF && mul_done) begin
			off_q <= {4'b0, cal_pressure_offset_q, 16'b0} + mul_prod[42:7];
		end
		if (state_q == ST_PRES && mul_done) begin
			p_q <= {{(OUT_W-(PDIF_W-15)){p_diff[PDIF_W-1]}}, p_diff[PDIF_W-1:15]};
		end
		if (res_load) begin
			res_q.temperature     <= temp_q;
			res_q.pressure        <= p_q;
			res_q.ground_pressure <= ground_next;
		end
	end

	// ground reference and result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ground_ref_q   <= '0;
			ground_valid_q <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (res_load) begin
				ground_ref_q   <= ground_next;
				ground_valid_q <= 1'b1;
				res_valid_q    <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

// ===== tb/tb_baro_pressure_temp_compensation.sv =====
// Testbench for the first-order barometric pressure and temperature compensation block.
// Streams directed and random sample words under several calibration sets and checks each
// result word against a predictor. Depends on bpc_pkg, bpc_if and the block's RTL.
`timescale 1ns / 1ps

module tb_baro_pressure_temp_compensation;
	import bpc_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 600;
	localparam int TAIL_CYCLES  = 150;
	localparam int IDLE_PCT     = 25;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 240;

	localparam logic [RAW_W-1:0] RAW_MAX = '1;
	localparam logic [CAL_W-1:0] CAL_MAX = '1;

	// indexes past the last calibration word, writes there must be dropped
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef logic [CAL_W-1:0] cal_set_t [6];

	// datasheet example: calibration words and a typical pair of conversions
	localparam cal_set_t TYPICAL_CAL = '{16'd40127, 16'd36924, 16'd23317,
		16'd23282, 16'd33464, 16'd28312};
	localparam logic [RAW_W-1:0] TYPICAL_D1 = 24'd9085466;
	localparam logic [RAW_W-1:0] TYPICAL_D2 = 24'd8569150;
	localparam logic [RAW_W-1:0] COLD_D2    = 24'd7000000;

	// Predicts every result word and checks the words that come out in order.
	class compensation_checker;
		logic [CAL_W-1:0] cal_word [6];
		logic [OUT_W-1:0] ground_ref;
		bit               ground_valid;
		bpc_result_t      expected_readings [$];
		int               samples;
		int               readings;
		int               relatches;
		int               errors;

		function new();
			foreach (cal_word[i])
				cal_word[i] = '0;
			ground_ref   = '0;
			ground_valid = 1'b0;
			samples      = 0;
			readings     = 0;
			relatches    = 0;
			errors       = 0;
		endfunction

		function void write_cal(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] value);
			if (idx <= REG_C6)
				cal_word[idx] = value;
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction

		// first-order compensation; every shift rounds toward minus infinity
		function bpc_result_t compensate(bpc_sample_t s);
			longint d1, d2, dt, temp, off, sens, p;
			longint c1, c2, c3, c4, c5, c6;
			bpc_result_t r;
			d1 = longint'(s.raw_pressure);
			d2 = longint'(s.raw_temperature);
			c1 = longint'(cal_word[REG_C1]);
			c2 = longint'(cal_word[REG_C2]);
			c3 = longint'(cal_word[REG_C3]);
			c4 = longint'(cal_word[REG_C4]);
			c5 = longint'(cal_word[REG_C5]);
			c6 = longint'(cal_word[REG_C6]);
			dt   = d2 - c5 * 256;
			temp = longint'(TEMP_BASE) + ((dt * c6) >>> 23);
			off  = c2 * 65536 + ((c4 * dt) >>> 7);
			sens = c1 * 32768 + ((c3 * dt) >>> 8);
			p    = (((d1 * sens) >>> 21) - off) >>> 15;
			// latch ground on the first sample and on every relatch request
			if (!ground_valid || s.relatch_ground) begin
				ground_ref   = p[OUT_W-1:0];
				ground_valid = 1'b1;
			end
			r.temperature     = temp[OUT_W-1:0];
			r.pressure        = p[OUT_W-1:0];
			r.ground_pressure = ground_ref;
			return r;
		endfunction

		function void take_sample(bpc_sample_t s);
			expected_readings.push_back(compensate(s));
			samples++;
			if (s.relatch_ground)
				relatches++;
		endfunction

		function void match_result(bpc_result_t got);
			bpc_result_t want;
			if (expected_readings.size() == 0) begin
				$error("result word arrived with no sample outstanding");
				errors++;
				return;
			end
			want = expected_readings.pop_front();
			readings++;
			if (got.temperature !== want.temperature) begin
				$error("temperature: expected %0d, actual %0d",
					want.temperature, got.temperature);
				errors++;
			end
			if (got.pressure !== want.pressure) begin
				$error("pressure: expected %0d, actual %0d", want.pressure, got.pressure);
				errors++;
			end
			if (got.ground_pressure !== want.ground_pressure) begin
				$error("ground_pressure: expected %0d, actual %0d",
					want.ground_pressure, got.ground_pressure);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	bit   hold_results = 1'b0;
	int   cal_sets = 0;
	int   cycle_count = 0;

	bpc_sample_if sample_ch ();
	bpc_result_if result_ch ();
	bpc_cfg_if    cfg_ch ();

	compensation_checker board = new();

	baro_pressure_temp_compensation dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// check every result word taken by the receiver
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			board.match_result(result_ch.data);
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_results) begin
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_results = 1'b0;
			end
			result_ch.ready = calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// abort a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// offer one sample word and hold it until taken; starts and ends at a falling edge
	task automatic send_sample(input bpc_sample_t s);
		while (take_break()) begin
			sample_ch.valid = 1'b0;
			@(negedge clk);
		end
		sample_ch.data  = s;
		sample_ch.valid = 1'b1;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		board.take_sample(s);
		@(negedge clk);
	endtask

	task automatic send_raw(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
			input logic relatch);
		bpc_sample_t s;
		s.raw_pressure    = d1;
		s.raw_temperature = d2;
		s.relatch_ground  = relatch;
		send_sample(s);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
		cfg_ch.index = idx;
		cfg_ch.wdata = value;
		cfg_ch.valid = 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		board.write_cal(idx, value);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic load_cal(input cal_set_t words);
		bpc_reg_t r;
		r = REG_C1;
		repeat (6) begin
			write_reg(r, words[r]);
			r = r.next();
		end
		cal_sets++;
	endtask

	// drop valid and wait until every outstanding result word is back
	task automatic settle();
		sample_ch.valid = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [CAL_W-1:0] pick_cal();
		unique case ($urandom_range(5))
			0: begin
				return '0;
			end
			1: begin
				return CAL_MAX;
			end
			default: begin
				return CAL_W'($urandom());
			end
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw();
		unique case ($urandom_range(7))
			0: begin
				return '0;
			end
			1: begin
				return RAW_MAX;
			end
			default: begin
				return RAW_W'($urandom());
			end
		endcase
	endfunction

	function automatic bpc_sample_t random_sample();
		bpc_sample_t s;
		int near;
		s.raw_pressure = pick_raw();
		// straddle the reference temperature so dT changes sign often
		if ($urandom_range(3) == 0) begin
			near = int'(board.cal_word[REG_C5]) * 256 + int'($urandom_range(4095)) - 2048;
			if (near < 0)
				near = 0;
			else if (near > int'(RAW_MAX))
				near = int'(RAW_MAX);
			s.raw_temperature = RAW_W'(near);
		end else begin
			s.raw_temperature = pick_raw();
		end
		s.relatch_ground = ($urandom_range(9) == 0);
		return s;
	endfunction

	initial begin
		cal_set_t words;
		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.wdata    = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// calibration still at reset; first sample latches ground
		send_raw(TYPICAL_D1, TYPICAL_D2, 1'b0);
		send_raw(RAW_MAX, '0, 1'b0);
		settle();

		// datasheet calibration: typical point, extremes, dT at and just under zero, cold
		load_cal(TYPICAL_CAL);
		send_raw(TYPICAL_D1, TYPICAL_D2, 1'b0);
		send_raw(TYPICAL_D1, TYPICAL_D2, 1'b1);
		send_raw('0, '0, 1'b0);
		send_raw(RAW_MAX, RAW_MAX, 1'b0);
		send_raw(TYPICAL_D1, {TYPICAL_CAL[REG_C5], 8'h00}, 1'b0);
		send_raw(TYPICAL_D1, {TYPICAL_CAL[REG_C5], 8'h00} - 1'b1, 1'b0);
		send_raw(TYPICAL_D1, COLD_D2, 1'b0);
		send_raw('0, TYPICAL_D2, 1'b1);
		settle();

		// all words at full scale; spare indexes must not disturb them
		foreach (words[i])
			words[i] = CAL_MAX;
		load_cal(words);
		write_reg(REG_SPARE_LO, '0);
		write_reg(REG_SPARE_HI, 16'h5a5a);
		send_raw(RAW_MAX, '0, 1'b0);
		send_raw(RAW_MAX, RAW_MAX, 1'b1);
		send_raw('0, RAW_MAX, 1'b0);
		send_raw('0, '0, 1'b0);
		settle();

		// all words zero
		foreach (words[i])
			words[i] = '0;
		load_cal(words);
		write_reg(REG_SPARE_HI, CAL_MAX);
		send_raw(RAW_MAX, RAW_MAX, 1'b0);
		send_raw(RAW_MAX, '0, 1'b1);

		// random phases, each under its own calibration set
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == 0) begin
				words = TYPICAL_CAL;
			end else begin
				foreach (words[i])
					words[i] = pick_cal();
			end
			load_cal(words);
			write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CAL_W'($urandom()));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				calm = (ph == 2 && n >= 60 && n < 160);
				if (ph == 3 && n == 50)
					hold_results = 1'b1;
				if (ph == 4 && n == 120)
					settle();
				send_sample(random_sample());
			end
		end
		calm = 1'b0;
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d samples (%0d ground relatches) over %0d calibration sets.",
			board.samples, board.relatches, cal_sets);
		$display("Compared %0d result words, %0d field mismatches.",
			board.readings, board.errors);
		if (board.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
